### rtl/core/kmp_pkg.sv
// Package for the KMP pattern matcher: request and response payload types
// and the operation codes. No dependencies.
package kmp_pkg;

   // Operation codes carried in the request.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // One request: a pattern byte or a text byte.
   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
      logic       last_byte;
   } kmp_req_type;

   // One response, produced for every text byte.
   typedef struct packed {
      logic        match;
      logic [31:0] match_position;
      logic        text_end;
      logic        any_found;
   } kmp_rsp_type;

endpackage

### rtl/core/kmp_fail_walk.sv
// Shared compare unit of the KMP matcher: holds the pattern and prefix
// table memories and walks the failure chain for one byte per command.
// Depends on nothing outside this file.
module kmp_fail_walk #(
   parameter int MAX_PATTERN = 64
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                start,
   input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] start_index,
   input  logic [7:0]                                          start_byte,
   output logic                                                done,
   output logic [$clog2(MAX_PATTERN + 1)-1:0]                  result_length,
   input  logic                                                wr_en,
   input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] wr_addr,
   input  logic [7:0]                                          wr_char,
   input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] wr_prefix
);

   localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);

   typedef enum logic [1:0] {
      W_IDLE,
      W_READ,
      W_CMP
   } walk_state_type;

   walk_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]   index_ff, index_in;
   logic [7:0]          byte_ff, byte_in;
   logic [7:0]          pattern_mem [MAX_PATTERN];
   logic [ADDR_W-1:0]   prefix_mem  [MAX_PATTERN];
   logic [7:0]          char_rd_ff;
   logic [ADDR_W-1:0]   prefix_rd_ff;
   logic                equal;

   // Memory writes come from the control block between walks.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pattern_mem[wr_addr] <= wr_char;
         prefix_mem[wr_addr]  <= wr_prefix;
      end
   end

   // Registered reads of the current candidate and of its fallback entry.
   // The fallback read at index zero is never used.
   always_ff @(posedge clock) begin
      char_rd_ff   <= pattern_mem[index_ff];
      prefix_rd_ff <= prefix_mem[index_ff - ADDR_W'(1)];
   end

   // One compare per step: a hit or index zero ends the walk, otherwise
   // the index falls back through the prefix table.
   assign equal         = (char_rd_ff == byte_ff);
   assign done          = (state_ff == W_CMP) && (equal || (index_ff == '0));
   assign result_length = equal ? (LEN_W'(index_ff) + LEN_W'(1)) : '0;

   always_comb begin
      state_in = state_ff;
      index_in = index_ff;
      byte_in  = byte_ff;
      case (state_ff)
         W_IDLE: begin
            if (start) begin
               index_in = start_index;
               byte_in  = start_byte;
               state_in = W_READ;
            end
         end
         W_READ: begin
            state_in = W_CMP;
         end
         W_CMP: begin
            if (done) begin
               state_in = W_IDLE;
            end else begin
               index_in = prefix_rd_ff;
               state_in = W_READ;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
      index_ff <= index_in;
      byte_ff  <= byte_in;
   end

endmodule

### rtl/core/kmp_pattern_matcher.sv
// KMP pattern matcher, top level: request/response handshake, pattern and
// search state, result register. Depends on kmp_pkg and kmp_fail_walk.
//
// Usage: send pattern bytes with operation OP_LOAD; last_byte closes the
// pattern. Bytes past MAX_PATTERN are dropped. Then send text bytes with
// operation OP_SEARCH; each gives one response with match, the start index
// of the occurrence, text_end (last_byte echoed, search context cleared) and
// any_found. A pattern byte after a closed pattern starts a new pattern.
// Each failure-table step of the compare unit is a memory read, then a
// compare. A text byte walks the failure chain, with at most as many
// fallback steps as the pattern length; with no closed pattern it skips
// the walk. A pattern byte skips the walk when it is the first or is
// dropped, else it walks the chain as well.
// One request is in work at a time; req_ready is high only while idle.
// A finished response sits in an output register; while rsp_ready is low the
// block still takes the next request and holds its result until the register
// frees. Reset clears all control state; the pattern memories are not
// cleared and are always written before they are read.
module kmp_pattern_matcher
   import kmp_pkg::*;
#(
   parameter int MAX_PATTERN = 64,
   parameter int INDEX_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  kmp_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output kmp_rsp_type rsp_payload
);

   localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int POS_W  = (INDEX_BITS + 1 > 32) ? INDEX_BITS + 1 : 32;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic                   op_ff, op_in;
   logic                   last_ff, last_in;
   logic [7:0]             byte_ff, byte_in;
   logic [LEN_W-1:0]       length_ff, length_in;
   logic [ADDR_W-1:0]      border_ff, border_in;
   logic                   ready_ff, ready_in;
   logic [LEN_W-1:0]       progress_ff, progress_in;
   logic [INDEX_BITS-1:0]  tpos_ff, tpos_in;
   logic                   found_ff, found_in;
   kmp_rsp_type            res_ff, res_in;
   kmp_rsp_type            rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   accept;
   logic                   walk_start;
   logic [ADDR_W-1:0]      walk_index;
   logic                   walk_done;
   logic [LEN_W-1:0]       walk_length;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [7:0]             wr_char;
   logic [ADDR_W-1:0]      wr_prefix;

   logic                   fin_go;
   logic                   fin_last;
   logic                   fin_hit;
   logic [POS_W-1:0]       end_pos;
   logic [POS_W-1:0]       len_wide;
   logic [POS_W-1:0]       start_pos;

   kmp_fail_walk #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .start        (walk_start),
      .start_index  (walk_index),
      .start_byte   (req_payload.data_byte),
      .done         (walk_done),
      .result_length(walk_length),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_char      (wr_char),
      .wr_prefix    (wr_prefix)
   );

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Start index of an occurrence ending at the current text byte.
   assign end_pos   = POS_W'(tpos_ff) + POS_W'(1);
   assign len_wide  = POS_W'(length_ff);
   assign start_pos = end_pos - len_wide;

   // A text byte finishes either right away (no closed pattern) or when
   // the walk over the failure chain is done.
   assign fin_hit  = (state_ff == S_WALK) && (walk_length == length_ff);
   assign fin_last = (state_ff == S_IDLE) ? req_payload.last_byte : last_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      byte_in      = byte_ff;
      length_in    = length_ff;
      border_in    = border_ff;
      ready_in     = ready_ff;
      progress_in  = progress_ff;
      tpos_in      = tpos_ff;
      found_in     = found_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      walk_start   = 1'b0;
      walk_index   = border_ff;
      wr_en        = 1'b0;
      wr_addr      = length_ff[ADDR_W-1:0];
      wr_char      = byte_ff;
      wr_prefix    = walk_length[ADDR_W-1:0];
      fin_go       = 1'b0;

      // The output register frees when its response is taken.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_payload.operation;
               last_in = req_payload.last_byte;
               byte_in = req_payload.data_byte;
               if (req_payload.operation == OP_LOAD) begin
                  if (ready_ff) begin
                     // A new pattern: drop the old one and its search context.
                     border_in   = '0;
                     progress_in = '0;
                     tpos_in     = '0;
                     found_in    = 1'b0;
                     wr_en       = 1'b1;
                     wr_addr     = '0;
                     wr_char     = req_payload.data_byte;
                     wr_prefix   = '0;
                     length_in   = LEN_W'(1);
                     ready_in    = req_payload.last_byte;
                  end else if (length_ff == LEN_W'(MAX_PATTERN)) begin
                     // Pattern full: the byte is dropped, its flag still counts.
                     ready_in = req_payload.last_byte;
                  end else if (length_ff == '0) begin
                     wr_en     = 1'b1;
                     wr_addr   = '0;
                     wr_char   = req_payload.data_byte;
                     wr_prefix = '0;
                     border_in = '0;
                     length_in = LEN_W'(1);
                     ready_in  = req_payload.last_byte;
                  end else begin
                     walk_start = 1'b1;
                     walk_index = border_ff;
                     state_in   = S_WALK;
                  end
               end else begin
                  if (ready_ff && (length_ff != '0)) begin
                     walk_start = 1'b1;
                     walk_index = (progress_ff >= length_ff) ? '0
                                                              : progress_ff[ADDR_W-1:0];
                     state_in   = S_WALK;
                  end else begin
                     fin_go   = 1'b1;
                     state_in = S_OUT;
                  end
               end
            end
         end
         S_WALK: begin
            if (walk_done) begin
               if (op_ff == OP_LOAD) begin
                  // Store the byte and its prefix entry.
                  wr_en     = 1'b1;
                  border_in = walk_length[ADDR_W-1:0];
                  length_in = length_ff + LEN_W'(1);
                  ready_in  = last_ff;
                  state_in  = S_IDLE;
               end else begin
                  progress_in = fin_hit ? LEN_W'(border_ff) : walk_length;
                  fin_go      = 1'b1;
                  state_in    = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Build the response of a text byte and advance the search context.
      if (fin_go) begin
         res_in.match          = fin_hit;
         res_in.match_position = (fin_hit && (end_pos >= len_wide)) ? start_pos[31:0]
                                                                     : 32'd0;
         res_in.text_end       = fin_last;
         res_in.any_found      = found_ff || fin_hit;
         found_in              = found_ff || fin_hit;
         if (tpos_ff != '1) begin
            tpos_in = tpos_ff + INDEX_BITS'(1);
         end
         if (fin_last) begin
            progress_in = '0;
            tpos_in     = '0;
            found_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         length_ff    <= '0;
         border_ff    <= '0;
         ready_ff     <= 1'b0;
         progress_ff  <= '0;
         tpos_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         border_ff    <= border_in;
         ready_ff     <= ready_in;
         progress_ff  <= progress_in;
         tpos_ff      <= tpos_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff   <= op_in;
      last_ff <= last_in;
      byte_ff <= byte_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   // The compare unit reports completion only while a walk is in progress.
   assert property (@(posedge clock) disable iff (reset)
      walk_done |-> (state_ff == S_WALK))
      else $error("walk completion outside of a walk");

   // A stored search position always lies inside the closed pattern.
   assert property (@(posedge clock) disable iff (reset)
      (ready_ff && (length_ff != '0)) |-> (progress_ff < length_ff))
      else $error("search progress beyond pattern length");

   // The running border is always shorter than the pattern loaded so far.
   assert property (@(posedge clock) disable iff (reset)
      (length_ff != '0) |-> (LEN_W'(border_ff) < length_ff))
      else $error("border length not below pattern length");

   // A response that reports a match also reports that a match was seen.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.match) |-> rsp_ff.any_found)
      else $error("match reported without any_found");

endmodule

### test/kmp_pattern_matcher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for kmp_pattern_matcher: directed table, then random pattern/text
// traffic checked against a behavioral KMP predictor. Depends on kmp_pkg and the matcher RTL.
module kmp_pattern_matcher_tb;
   import kmp_pkg::*;

   localparam int MAX_PAT = 64;
   localparam longint unsigned IDX_MAX = (64'd1 << 32) - 1;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int MAX_PRINTED = 40;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   kmp_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   kmp_rsp_type rsp_payload;

   // One line of the directed table; typed rows carry their response inline.
   typedef struct {
      kmp_req_type req;
      bit          typed;
      kmp_rsp_type rsp;
   } table_row_type;

   table_row_type directed_rows[$];
   kmp_rsp_type   results_due[$];

   // Predictor state: pattern, failure table and search context.
   byte unsigned    pat_mem[MAX_PAT];
   int unsigned     fail_tab[MAX_PAT];
   int unsigned     pat_len;
   int unsigned     border_len;
   int unsigned     match_len;
   bit              pat_closed;
   bit              seen_match;
   longint unsigned text_idx;

   int send_idle_pct;
   int recv_stall_pct;
   int sent_count;
   int checked_count;
   int hit_count;
   int error_count;
   int patterns_closed;
   int dropped_bytes;
   int cycle_count;

   kmp_pattern_matcher u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // The receiver stalls at random with the current stall rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Watchdog on total cycles.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, results_due.size());
         $display("kmp_pattern_matcher_tb NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < MAX_PRINTED)
         $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic void clear_search();
      match_len  = 0;
      text_idx   = 0;
      seen_match = 1'b0;
   endfunction

   // Applies one request to the predictor; returns 1 when it yields a response.
   function automatic bit advance_matcher(input kmp_req_type r, output kmp_rsp_type rsp);
      int unsigned     k;
      longint unsigned start;
      bit              hit;
      rsp = '0;
      if (r.operation == OP_LOAD) begin
         // A pattern byte after a closed pattern starts over.
         if (pat_closed) begin
            pat_len    = 0;
            border_len = 0;
            pat_closed = 1'b0;
            clear_search();
         end
         if (pat_len < MAX_PAT) begin
            k = 0;
            if (pat_len > 0) begin
               k = border_len;
               while (k > 0 && pat_mem[k] != r.data_byte)
                  k = fail_tab[k - 1];
               if (pat_mem[k] == r.data_byte)
                  k++;
            end
            pat_mem[pat_len]  = r.data_byte;
            fail_tab[pat_len] = k;
            border_len        = k;
            pat_len++;
         end else begin
            dropped_bytes++;
         end
         if (r.last_byte) begin
            pat_closed = 1'b1;
            patterns_closed++;
         end
         return 1'b0;
      end
      hit   = 1'b0;
      start = 0;
      // Text byte: walk the failure chain only once a pattern is closed.
      if (pat_closed && pat_len > 0) begin
         k = match_len;
         if (k >= pat_len)
            k = 0;
         while (k > 0 && pat_mem[k] != r.data_byte)
            k = fail_tab[k - 1];
         if (pat_mem[k] == r.data_byte)
            k++;
         if (k == pat_len) begin
            hit        = 1'b1;
            seen_match = 1'b1;
            if (text_idx + 1 >= pat_len)
               start = text_idx + 1 - pat_len;
            k = fail_tab[pat_len - 1];
         end
         match_len = k;
      end
      rsp.match          = hit;
      rsp.match_position = start[31:0];
      rsp.text_end       = r.last_byte;
      rsp.any_found      = seen_match;
      if (text_idx < IDX_MAX)
         text_idx++;
      if (r.last_byte)
         clear_search();
      return 1'b1;
   endfunction

   function automatic kmp_req_type make_req(input logic op, input byte unsigned data,
                                            input logic last);
      kmp_req_type r;
      r.operation = op;
      r.data_byte = data;
      r.last_byte = last;
      return r;
   endfunction

   function automatic void add_row(input logic op, input byte unsigned data, input logic last,
                                   input bit typed = 1'b0, input bit m = 1'b0,
                                   input int unsigned pos = 0, input bit te = 1'b0,
                                   input bit any = 1'b0);
      table_row_type row;
      row.req                = make_req(op, data, last);
      row.typed              = typed;
      row.rsp.match          = m;
      row.rsp.match_position = pos;
      row.rsp.text_end       = te;
      row.rsp.any_found      = any;
      directed_rows.push_back(row);
   endfunction

   // Sends one request, idling first at the sender's rate, and records its response.
   task automatic send_request(input kmp_req_type item, input bit typed = 1'b0,
                               input kmp_rsp_type typed_rsp = '0);
      kmp_rsp_type due;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sent_count++;
      if (advance_matcher(item, due))
         results_due.push_back(typed ? typed_rsp : due);
   endtask

   // The sender goes quiet until every expected response has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (results_due.size() != 0)
         @(posedge clock);
   endtask

   function automatic byte unsigned pick_byte(input byte unsigned alpha[3], input int asize,
                                              input bit full_range);
      if (full_range)
         return 8'($urandom);
      return alpha[$urandom_range(0, asize - 1)];
   endfunction

   // Random traffic: mostly a pattern followed by text drawn from the same small alphabet,
   // plus unclosed patterns with text in between and raw random requests.
   task automatic run_random(input int quota);
      int           stop_at;
      int           pick;
      int           plen;
      int           tlen;
      int           n;
      int           i;
      int           asize;
      bit           full_range;
      byte unsigned alpha[3];
      byte unsigned pat[$];
      stop_at = sent_count + quota;
      while (sent_count < stop_at) begin
         pick = $urandom_range(0, 99);
         for (i = 0; i < 3; i++)
            alpha[i] = 8'($urandom);
         asize      = $urandom_range(2, 3);
         full_range = ($urandom_range(0, 9) == 0);
         if (pick < 80) begin
            n = $urandom_range(0, 99);
            if (n < 80)
               plen = $urandom_range(1, 6);
            else if (n < 95)
               plen = $urandom_range(7, 20);
            else
               plen = $urandom_range(60, 70);
            pat.delete();
            for (i = 0; i < plen; i++)
               pat.push_back(pick_byte(alpha, asize, 1'b0));
            for (i = 0; i < plen; i++)
               send_request(make_req(OP_LOAD, pat[i], i == plen - 1));
            // Text mixes whole copies of the pattern with random alphabet bytes.
            tlen = (plen > 20) ? $urandom_range(plen, 2 * plen) : $urandom_range(1, 40);
            n = 0;
            while (n < tlen) begin
               if ($urandom_range(0, 3) == 0) begin
                  for (i = 0; i < plen; i++)
                     send_request(make_req(OP_SEARCH, pat[i], 1'b0));
                  n += plen;
               end else begin
                  send_request(make_req(OP_SEARCH, pick_byte(alpha, asize, full_range), 1'b0));
                  n++;
               end
            end
            // Usually the text ends; otherwise the next pattern cuts it off.
            send_request(make_req(OP_SEARCH, pick_byte(alpha, asize, full_range),
                                  $urandom_range(0, 9) != 0));
         end else if (pick < 90) begin
            // Pattern left open while text arrives.
            repeat ($urandom_range(1, 5))
               send_request(make_req(OP_LOAD, pick_byte(alpha, asize, full_range), 1'b0));
            repeat ($urandom_range(1, 6))
               send_request(make_req(OP_SEARCH, pick_byte(alpha, asize, full_range),
                                     $urandom_range(0, 3) == 0));
         end else begin
            repeat ($urandom_range(1, 20))
               send_request(make_req(1'($urandom_range(0, 1)), 8'($urandom),
                                     1'($urandom_range(0, 1))));
         end
         if ($urandom_range(0, 49) == 0)
            wait_drained();
      end
   endtask

   // Response checker: every accepted response against the oldest expectation.
   always @(posedge clock) begin
      kmp_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         checked_count++;
         if (rsp_payload.match === 1'b1)
            hit_count++;
         if (results_due.size() == 0) begin
            report_mismatch("response with nothing expected", rsp_payload.match_position,
                            32'd0);
         end else begin
            want = results_due.pop_front();
            if (rsp_payload.match !== want.match)
               report_mismatch("match", 32'(rsp_payload.match), 32'(want.match));
            if (rsp_payload.match_position !== want.match_position)
               report_mismatch("match_position", rsp_payload.match_position,
                               want.match_position);
            if (rsp_payload.text_end !== want.text_end)
               report_mismatch("text_end", 32'(rsp_payload.text_end), 32'(want.text_end));
            if (rsp_payload.any_found !== want.any_found)
               report_mismatch("any_found", 32'(rsp_payload.any_found),
                               32'(want.any_found));
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      send_idle_pct  = 18;
      recv_stall_pct = 48;
      pat_len        = 0;
      border_len     = 0;
      pat_closed     = 1'b0;
      clear_search();

      // Text before any pattern, pattern of two equal bytes with overlapping hits,
      // a new pattern cutting into open text, text between open pattern bytes,
      // and a one-byte pattern; data bytes reach both extremes.
      add_row(OP_SEARCH, 8'h00, 1'b0, 1'b1, 1'b0, 0, 1'b0, 1'b0);
      add_row(OP_SEARCH, 8'hFF, 1'b1, 1'b1, 1'b0, 0, 1'b1, 1'b0);
      add_row(OP_LOAD,   8'hAA, 1'b0);
      add_row(OP_LOAD,   8'hAA, 1'b1);
      add_row(OP_SEARCH, 8'hAA, 1'b0);
      add_row(OP_SEARCH, 8'hAA, 1'b0, 1'b1, 1'b1, 0, 1'b0, 1'b1);
      add_row(OP_SEARCH, 8'hAA, 1'b0, 1'b1, 1'b1, 1, 1'b0, 1'b1);
      add_row(OP_SEARCH, 8'h55, 1'b0);
      add_row(OP_SEARCH, 8'hAA, 1'b0);
      add_row(OP_SEARCH, 8'hAA, 1'b1, 1'b1, 1'b1, 4, 1'b1, 1'b1);
      add_row(OP_SEARCH, 8'hAA, 1'b0);
      add_row(OP_LOAD,   8'h00, 1'b0);
      add_row(OP_LOAD,   8'hFF, 1'b1);
      add_row(OP_SEARCH, 8'h00, 1'b0);
      add_row(OP_SEARCH, 8'hFF, 1'b1, 1'b1, 1'b1, 0, 1'b1, 1'b1);
      add_row(OP_LOAD,   8'h7F, 1'b0);
      add_row(OP_SEARCH, 8'h7F, 1'b0, 1'b1, 1'b0, 0, 1'b0, 1'b0);
      add_row(OP_LOAD,   8'h80, 1'b1);
      add_row(OP_SEARCH, 8'h7F, 1'b0);
      add_row(OP_SEARCH, 8'h80, 1'b1);
      add_row(OP_LOAD,   8'h80, 1'b1);
      add_row(OP_SEARCH, 8'h80, 1'b1, 1'b1, 1'b1, 0, 1'b1, 1'b1);
      add_row(OP_SEARCH, 8'h01, 1'b1, 1'b1, 1'b0, 0, 1'b1, 1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n])
         send_request(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].rsp);

      // Three idle regimes: slow receiver, slow sender, then full rate.
      run_random(510);
      wait_drained();
      send_idle_pct  = 48;
      recv_stall_pct = 18;
      run_random(510);
      wait_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(510);

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (results_due.size() != 0)
         report_mismatch("responses never received", results_due.size(), 32'd0);
      $display("Coverage: %0d requests over three idle regimes, %0d responses checked, %0d hits",
               sent_count, checked_count, hit_count);
      $display("Patterns closed: %0d, pattern bytes dropped on overflow: %0d, mismatches: %0d",
               patterns_closed, dropped_bytes, error_count);
      if (error_count == 0) begin
         $display("kmp_pattern_matcher_tb OK");
      end else begin
         $display("kmp_pattern_matcher_tb NOT OK");
      end
      $finish;
   end

endmodule
